// File: rtl/gwno_pkg.sv
// shared types and constants for the grid window nearest obstacle core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gwno_pkg;
  localparam int MAX_SIDE = 256;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIDE_W = $clog2(MAX_SIDE);
  localparam int DIV_STEPS = 33;
  localparam int SQRT_STEPS = 32;

  localparam logic [2:0] REG_BASE_X = 3'd0;
  localparam logic [2:0] REG_BASE_Y = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_GRID_WIDTH = 3'd3;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  typedef enum logic [1:0] {DIV_X, DIV_Y, DIV_R} div_src_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_DIVX, ST_LDY, ST_DIVY, ST_LDR, ST_DIVR,
    ST_WIN, ST_SETUP, ST_SCAN, ST_DRAIN, ST_SQRT, ST_FIN
  } state_t;

  typedef struct packed {
    logic     accept_write;
    logic     accept_query;
    logic     mark_invalid;
    logic     div_load;
    div_src_t div_src;
    logic     div_step;
    logic     store_cx;
    logic     store_cy;
    logic     window;
    logic     setup;
    logic     scan;
    logic     sqrt_load;
    logic     sqrt_step;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic geom_ok;
    logic cell_ok;
    logic scan_last;
    logic pipe_busy;
    logic found;
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/gwno_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module gwno_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/gwno_ctrl.sv
// query sequencer for the nearest obstacle core
// depends on gwno_pkg
`timescale 1ns / 1ps
`default_nettype none
module gwno_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           operation,
  output      logic           in_stall,
  input  wire gwno_pkg::stat_t stat,
  output      gwno_pkg::cmd_t  cmd
);
  gwno_pkg::state_t state, state_next;
  logic [5:0] cnt, cnt_next;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gwno_pkg::ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  assign in_stall = (state != gwno_pkg::ST_IDLE);
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    cmd.div_src = gwno_pkg::DIV_X;
    case (state)
      gwno_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation == gwno_pkg::OP_QUERY) begin
            cmd.accept_query = 1'b1;
            state_next = gwno_pkg::ST_CHECK;
          end else begin
            cmd.accept_write = 1'b1;
          end
        end
      end
      gwno_pkg::ST_CHECK: begin
        if (!stat.geom_ok) begin
          cmd.mark_invalid = 1'b1;
          state_next = gwno_pkg::ST_FIN;
        end else begin
          cmd.div_load = 1'b1;
          cmd.div_src = gwno_pkg::DIV_X;
          cnt_next = '0;
          state_next = gwno_pkg::ST_DIVX;
        end
      end
      gwno_pkg::ST_DIVX, gwno_pkg::ST_DIVY, gwno_pkg::ST_DIVR: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(gwno_pkg::DIV_STEPS - 1)) begin
          cnt_next = '0;
          case (state)
            gwno_pkg::ST_DIVX: state_next = gwno_pkg::ST_LDY;
            gwno_pkg::ST_DIVY: state_next = gwno_pkg::ST_LDR;
            default: state_next = gwno_pkg::ST_WIN;
          endcase
        end
      end
      gwno_pkg::ST_LDY: begin
        cmd.store_cx = 1'b1;
        cmd.div_load = 1'b1;
        cmd.div_src = gwno_pkg::DIV_Y;
        state_next = gwno_pkg::ST_DIVY;
      end
      gwno_pkg::ST_LDR: begin
        cmd.store_cy = 1'b1;
        cmd.div_load = 1'b1;
        cmd.div_src = gwno_pkg::DIV_R;
        state_next = gwno_pkg::ST_DIVR;
      end
      gwno_pkg::ST_WIN: begin
        if (!stat.cell_ok) begin
          cmd.mark_invalid = 1'b1;
          state_next = gwno_pkg::ST_FIN;
        end else begin
          cmd.window = 1'b1;
          state_next = gwno_pkg::ST_SETUP;
        end
      end
      gwno_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_next = gwno_pkg::ST_SCAN;
      end
      gwno_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = gwno_pkg::ST_DRAIN;
        end
      end
      gwno_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          if (stat.found) begin
            cmd.sqrt_load = 1'b1;
            cnt_next = '0;
            state_next = gwno_pkg::ST_SQRT;
          end else begin
            state_next = gwno_pkg::ST_FIN;
          end
        end
      end
      gwno_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(gwno_pkg::SQRT_STEPS - 1)) begin
          state_next = gwno_pkg::ST_FIN;
        end
      end
      gwno_pkg::ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = gwno_pkg::ST_IDLE;
        end
      end
      default: state_next = gwno_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/gwno_dp.sv
// datapath: config registers, cell memory, divider, window scan, square root
// depends on gwno_pkg and gwno_ram
`timescale 1ns / 1ps
`default_nettype none
module gwno_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gwno_pkg::cmd_t     cmd,
  output      gwno_pkg::stat_t    stat,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [15:0]        cell_index,
  input  wire logic signed [7:0]  cell_value,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] search_radius,
  input  wire logic signed [7:0]  min_occupancy,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [31:0]        clearance,
  output      logic [1:0]         query_status
);
  localparam int SW = gwno_pkg::SIDE_W;
  localparam int AW = gwno_pkg::ADDR_W;

  logic signed [31:0] base_x, base_y;
  logic [30:0] cell_size;
  logic [8:0] grid_width, grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x <= '0;
      base_y <= '0;
      cell_size <= 31'd65536;
      grid_width <= 9'(gwno_pkg::MAX_SIDE);
      grid_height <= 9'(gwno_pkg::MAX_SIDE);
    end else if (cfg_write) begin
      case (cfg_index)
        gwno_pkg::REG_BASE_X: base_x <= cfg_data;
        gwno_pkg::REG_BASE_Y: base_y <= cfg_data;
        gwno_pkg::REG_CELL_SIZE: cell_size <= cfg_data[30:0];
        gwno_pkg::REG_GRID_WIDTH: grid_width <= cfg_data[8:0];
        gwno_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // query latch
  logic signed [31:0] qx_pt, qy_pt, q_rad;
  logic signed [7:0] q_min;
  logic inval;
  always_ff @(posedge clk) begin
    if (cmd.accept_query) begin
      qx_pt <= point_x;
      qy_pt <= point_y;
      q_rad <= search_radius;
      q_min <= min_occupancy;
    end
  end
  always_ff @(posedge clk) begin
    if (rst || cmd.accept_query) begin
      inval <= 1'b0;
    end else if (cmd.mark_invalid) begin
      inval <= 1'b1;
    end
  end

  logic signed [32:0] dx, dy;
  assign dx = 33'(qx_pt) - 33'(base_x);
  assign dy = 33'(qy_pt) - 33'(base_y);

  assign stat.geom_ok = (cell_size != '0) && (grid_width != '0) && (grid_height != '0)
    && (grid_width <= 9'(gwno_pkg::MAX_SIDE)) && (grid_height <= 9'(gwno_pkg::MAX_SIDE))
    && !dx[32] && !dy[32];

  // restoring divider by cell_size
  logic [32:0] div_rem, div_quo, div_dvd, rem_sh;
  logic [33:0] diff;
  always_comb begin
    case (cmd.div_src)
      gwno_pkg::DIV_X: div_dvd = dx;
      gwno_pkg::DIV_Y: div_dvd = dy;
      default: div_dvd = (q_rad[31] ? 33'd0 : 33'(q_rad)) + 33'(cell_size) - 33'd1;
    endcase
  end
  assign rem_sh = {div_rem[31:0], div_quo[32]};
  assign diff = {1'b0, rem_sh} - {3'b0, cell_size};
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_rem <= '0;
      div_quo <= div_dvd;
    end else if (cmd.div_step) begin
      if (!diff[33]) begin
        div_rem <= diff[32:0];
        div_quo <= {div_quo[31:0], 1'b1};
      end else begin
        div_rem <= rem_sh;
        div_quo <= {div_quo[31:0], 1'b0};
      end
    end
  end

  logic [SW-1:0] cx, cy;
  logic cx_ok, cy_ok;
  always_ff @(posedge clk) begin
    if (cmd.store_cx) begin
      cx <= div_quo[SW-1:0];
      cx_ok <= div_quo < 33'(grid_width);
    end
    if (cmd.store_cy) begin
      cy <= div_quo[SW-1:0];
      cy_ok <= div_quo < 33'(grid_height);
    end
  end
  assign stat.cell_ok = cx_ok && cy_ok;

  // window bounds
  logic [SW:0] rs;
  logic signed [SW+1:0] xlo, xhi, ylo, yhi;
  logic [SW-1:0] x0, x1, y0, y1;
  assign rs = (div_quo > 33'(gwno_pkg::MAX_SIDE)) ? (SW+1)'(gwno_pkg::MAX_SIDE)
                                                   : div_quo[SW:0];
  assign xlo = $signed({2'b0, cx}) - $signed({1'b0, rs});
  assign xhi = $signed({2'b0, cx}) + $signed({1'b0, rs});
  assign ylo = $signed({2'b0, cy}) - $signed({1'b0, rs});
  assign yhi = $signed({2'b0, cy}) + $signed({1'b0, rs});
  always_ff @(posedge clk) begin
    if (cmd.window) begin
      x0 <= xlo[SW+1] ? '0 : xlo[SW-1:0];
      y0 <= ylo[SW+1] ? '0 : ylo[SW-1:0];
      x1 <= (xhi > $signed({1'b0, grid_width - 9'd1})) ? SW'(grid_width - 9'd1)
                                                        : xhi[SW-1:0];
      y1 <= (yhi > $signed({1'b0, grid_height - 9'd1})) ? SW'(grid_height - 9'd1)
                                                         : yhi[SW-1:0];
    end
  end

  // scan counters, offsets in Q.17 units
  logic [SW-1:0] sx, sy;
  logic [AW-1:0] row_base;
  logic signed [43:0] ex, ey, ex_start, step2;
  logic [39:0] px0, py0;
  assign px0 = {{30{1'b0}}, x0, 1'b1} * {9'b0, cell_size};
  assign py0 = {{30{1'b0}}, y0, 1'b1} * {9'b0, cell_size};
  assign step2 = {12'b0, cell_size, 1'b0};
  assign stat.scan_last = (sx == x1) && (sy == y1);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      sx <= x0;
      sy <= y0;
      row_base <= AW'(y0) * AW'(grid_width);
      ex <= 44'(signed'({dx, 1'b0})) - {4'b0, px0};
      ex_start <= 44'(signed'({dx, 1'b0})) - {4'b0, px0};
      ey <= 44'(signed'({dy, 1'b0})) - {4'b0, py0};
    end else if (cmd.scan) begin
      if (sx == x1) begin
        sx <= x0;
        sy <= sy + SW'(1);
        row_base <= row_base + AW'(grid_width);
        ex <= ex_start;
        ey <= ey - step2;
      end else begin
        sx <= sx + SW'(1);
        ex <= ex - step2;
      end
    end
  end

  logic [7:0] rdata;
  gwno_ram #(.WIDTH(8), .DEPTH(gwno_pkg::DEPTH)) u_cells (
    .clk   (clk),
    .we    (cmd.accept_write),
    .waddr (cell_index),
    .wdata (cell_value),
    .raddr (row_base + AW'(sx)),
    .rdata (rdata)
  );

  function automatic logic [63:0] qsq(input logic signed [43:0] d);
    logic [43:0] u;
    logic [42:0] a;
    u = d[43] ? 44'(-d) : 44'(d);
    a = u[43:1];
    if (a[42:32] != '0) begin
      qsq = '1;
    end else begin
      qsq = a[31:0] * a[31:0] + (u[0] ? 64'(a[31:0]) : 64'd0);
    end
  endfunction

  // stage 1: memory data back, squares
  logic p1, p2, hit2;
  logic signed [43:0] ex1, ey1;
  logic [63:0] qx2, qy2, best;
  logic found;
  logic [64:0] ssum;
  assign ssum = {1'b0, qx2} + {1'b0, qy2};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= cmd.scan;
      p2 <= p1;
    end
    ex1 <= ex;
    ey1 <= ey;
    hit2 <= $signed(rdata) >= q_min;
    qx2 <= qsq(ex1);
    qy2 <= qsq(ey1);
  end
  assign stat.pipe_busy = p1 || p2;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      found <= 1'b0;
      best <= '1;
    end else if (p2 && hit2) begin
      found <= 1'b1;
      if (ssum[64]) begin
        if (!found) best <= '1;
      end else if (!found || ssum[63:0] < best) begin
        best <= ssum[63:0];
      end
    end
  end
  assign stat.found = found;

  // bit pair square root
  logic [63:0] sq_val;
  logic [34:0] sq_rem, sq_sh, sq_trial;
  logic [31:0] sq_res;
  assign sq_sh = {sq_rem[32:0], sq_val[63:62]};
  assign sq_trial = {1'b0, sq_res, 2'b01};
  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      sq_val <= best;
      sq_rem <= '0;
      sq_res <= '0;
    end else if (cmd.sqrt_step) begin
      sq_val <= {sq_val[61:0], 2'b00};
      if (sq_sh >= sq_trial) begin
        sq_rem <= sq_sh - sq_trial;
        sq_res <= {sq_res[30:0], 1'b1};
      end else begin
        sq_rem <= sq_sh;
        sq_res <= {sq_res[30:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) begin
      if (inval) begin
        clearance <= '0;
        query_status <= gwno_pkg::STATUS_INVALID;
      end else if (found) begin
        clearance <= sq_res;
        query_status <= gwno_pkg::STATUS_FOUND;
      end else begin
        clearance <= '1;
        query_status <= gwno_pkg::STATUS_NONE;
      end
    end
  end
  assign stat.out_busy = out_valid && out_stall;
endmodule
`default_nettype wire

// File: rtl/grid_window_nearest_obstacle_core.sv
// top level of the grid window nearest obstacle core
// depends on gwno_pkg, gwno_ctrl, gwno_dp
// a cell write is taken while idle; a query runs three divisions on the shared serial
// divider, scans the window through the single memory read port (one cell a cycle),
// then takes a square root when an obstacle is found
// one item at a time; synchronous reset restores register defaults, cells undefined
`timescale 1ns / 1ps
`default_nettype none
module grid_window_nearest_obstacle_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               operation,
  input  wire logic [15:0]        cell_index,
  input  wire logic signed [7:0]  cell_value,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] search_radius,
  input  wire logic signed [7:0]  min_occupancy,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [31:0]        clearance,
  output      logic [1:0]         query_status
);
  gwno_pkg::cmd_t cmd;
  gwno_pkg::stat_t stat;

  gwno_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  gwno_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cell_index    (cell_index),
    .cell_value    (cell_value),
    .point_x       (point_x),
    .point_y       (point_y),
    .search_radius (search_radius),
    .min_occupancy (min_occupancy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .clearance     (clearance),
    .query_status  (query_status)
  );
endmodule
`default_nettype wire

// File: test/tb_grid_window_nearest_obstacle_core.sv
// testbench for grid_window_nearest_obstacle_core: loads the cell memory, then runs
// directed and random cell writes and clearance queries over several grid geometries
// depends on gwno_pkg and the core; predicts every result and checks it in order
`timescale 1ns / 1ps
`default_nettype none
module tb_grid_window_nearest_obstacle_core;
  // every valid geometry keeps width times height within the loaded cells
  localparam int LOAD_CELLS = 512;

  typedef struct {
    logic               op;
    logic [15:0]        idx;
    logic signed [7:0]  val;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] rad;
    logic signed [7:0]  occ;
  } grid_req_t;

  typedef struct {
    logic [31:0] clr;
    logic [1:0]  status;
  } clearance_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_write = 0;
  logic [2:0]         cfg_index = 0;
  logic [31:0]        cfg_data = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               operation = 0;
  logic [15:0]        cell_index = 0;
  logic signed [7:0]  cell_value = 0;
  logic signed [31:0] point_x = 0;
  logic signed [31:0] point_y = 0;
  logic signed [31:0] search_radius = 0;
  logic signed [7:0]  min_occupancy = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [31:0]        clearance;
  logic [1:0]         query_status;

  grid_window_nearest_obstacle_core DUT (.*);

  initial forever #4 clk = ~clk;

  // predictor copy of the configuration and cell memory
  logic [31:0] m_ox = 0, m_oy = 0;
  logic [30:0] m_cs = 31'd65536;
  logic [8:0]  m_w = 9'd256, m_h = 9'd256;
  logic [7:0]  occ_mem [0:65535];

  grid_req_t  pend_q[$];
  clearance_t clear_q[$];
  grid_req_t  cur;
  int errors = 0;
  int burst_left = 0, gap_left = 0;
  int stall_mode = 0, stall_left = 0;
  int idle_cycles = 0;

  function automatic longint unsigned quarter_sq(longint d);
    longint unsigned u, a, b;
    u = d < 0 ? longint'(-d) : longint'(d);
    a = u >> 1;
    b = u & 1;
    if (a >= 64'h1_0000_0000) return '1;
    return a * a + a * b;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, res, bt;
    rem = v; res = 0; bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // applies one accepted item to the model and queues its clearance if it is a query
  function automatic void apply_item(grid_req_t it);
    longint px, py, ox, oy, cs, w, h, cx, cy, r, rd, x0, x1, y0, y1, ex, ey;
    longint unsigned best, qx, qy, s;
    clearance_t res;
    bit found;
    if (it.op == gwno_pkg::OP_WRITE) begin
      occ_mem[it.idx] = it.val;
      return;
    end
    px = it.px; py = it.py; rd = it.rad;
    ox = $signed(m_ox); oy = $signed(m_oy);
    cs = m_cs; w = m_w; h = m_h;
    res.clr = 0;
    res.status = gwno_pkg::STATUS_INVALID;
    found = 0;
    best = '1;
    if (cs != 0 && w != 0 && h != 0 && w <= gwno_pkg::MAX_SIDE &&
        h <= gwno_pkg::MAX_SIDE && px - ox >= 0 && py - oy >= 0) begin
      cx = (px - ox) / cs;
      cy = (py - oy) / cs;
      if (cx < w && cy < h) begin
        if (rd < 0) rd = 0;
        r = (rd + cs - 1) / cs;
        x0 = cx - r < 0 ? 0 : cx - r;
        x1 = cx + r > w - 1 ? w - 1 : cx + r;
        y0 = cy - r < 0 ? 0 : cy - r;
        y1 = cy + r > h - 1 ? h - 1 : cy + r;
        for (longint y = y0; y <= y1; y++) begin
          for (longint x = x0; x <= x1; x++) begin
            if ($signed(occ_mem[y * w + x]) >= it.occ) begin
              ex = 2 * px - 2 * ox - (2 * x + 1) * cs;
              ey = 2 * py - 2 * oy - (2 * y + 1) * cs;
              qx = quarter_sq(ex);
              qy = quarter_sq(ey);
              s = (qx > ~qy) ? '1 : qx + qy;
              if (!found || s < best) best = s;
              found = 1;
            end
          end
        end
        if (found) begin
          res.clr = 32'(int_sqrt(best));
          res.status = gwno_pkg::STATUS_FOUND;
        end else begin
          res.clr = '1;
          res.status = gwno_pkg::STATUS_NONE;
        end
      end
    end
    clear_q.insert(clear_q.size(), res);
  endfunction

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      in_valid <= 0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) apply_item(cur);
      if (!in_valid || !in_stall) begin
        nv = 0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          nv = 1;
          operation <= cur.op;
          cell_index <= cur.idx;
          cell_value <= cur.val;
          point_x <= cur.px;
          point_y <= cur.py;
          search_radius <= cur.rad;
          min_occupancy <= cur.occ;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
      in_valid <= nv;
    end
  end

  // receiver: stall pattern switching between modes
  always @(posedge clk) begin
    clearance_t exp_r;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (clear_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer: clearance %h status %0d",
                                     clearance, query_status);
        end else begin
          exp_r = clear_q.pop_front();
          if (clearance !== exp_r.clr || query_status !== exp_r.status) begin
            errors++;
            if (errors <= 10)
              $display("clearance exp %h/%0d got %h/%0d", exp_r.clr, exp_r.status,
                       clearance, query_status);
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= $urandom_range(0, 1);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("grid_window_nearest_obstacle_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      gwno_pkg::REG_BASE_X: m_ox = data;
      gwno_pkg::REG_BASE_Y: m_oy = data;
      gwno_pkg::REG_CELL_SIZE: m_cs = data[30:0];
      gwno_pkg::REG_GRID_WIDTH: m_w = data[8:0];
      default: m_h = data[8:0];
    endcase
    @(posedge clk);
    cfg_write <= 0;
  endtask

  // sampled away from the rising edge so that queue and valid updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pend_q.size() > 0 || in_valid || clear_q.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_geometry(logic [31:0] ox, logic [31:0] oy, logic [31:0] cs,
                              logic [31:0] w, logic [31:0] h);
    wait_idle();
    set_reg(gwno_pkg::REG_BASE_X, ox);
    set_reg(gwno_pkg::REG_BASE_Y, oy);
    set_reg(gwno_pkg::REG_CELL_SIZE, cs);
    set_reg(gwno_pkg::REG_GRID_WIDTH, w);
    set_reg(gwno_pkg::REG_GRID_HEIGHT, h);
  endtask

  function automatic logic signed [7:0] rand_occ();
    case ($urandom_range(0, 5))
      0: return -8'sd1;
      1: return 8'sd0;
      2: return 8'sd100;
      3: return 8'sd50;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_write(logic [15:0] idx, logic signed [7:0] v);
    grid_req_t it;
    it = '{gwno_pkg::OP_WRITE, idx, v, $urandom, $urandom, $urandom, 8'($urandom)};
    pend_q.insert(pend_q.size(), it);
  endtask

  task automatic push_query(longint px, longint py, longint rd, logic signed [7:0] occ);
    grid_req_t it;
    if (rd > 64'sh7FFF_FFFF) rd = 64'sh7FFF_FFFF;
    it = '{gwno_pkg::OP_QUERY, 16'($urandom), 8'($urandom), 32'(px), 32'(py), 32'(rd),
           occ};
    pend_q.insert(pend_q.size(), it);
  endtask

  // query mostly near the grid, window of at most max_r cells each way but for rare random radii
  task automatic rand_query(int max_r);
    longint we, he, cs, px, py, rd;
    we = (m_w == 0 || m_w > gwno_pkg::MAX_SIDE) ? 8 : m_w;
    he = (m_h == 0 || m_h > gwno_pkg::MAX_SIDE) ? 8 : m_h;
    cs = (m_cs == 0) ? 1 : m_cs;
    px = $signed(m_ox) + $urandom_range(0, we - 1) * cs + ({$urandom} % cs);
    py = $signed(m_oy) + $urandom_range(0, he - 1) * cs + ({$urandom} % cs);
    if ($urandom_range(0, 7) == 0) px = $signed($urandom);
    if ($urandom_range(0, 7) == 0) py = $signed($urandom);
    rd = $urandom_range(0, max_r) * cs - ({$urandom} % cs);
    if (rd < 0) rd = 0;
    if ($urandom_range(0, 15) == 0) rd = -longint'($urandom_range(1, 100000));
    if ($urandom_range(0, 31) == 0 && we * he <= 256) rd = $signed($urandom);
    push_query(px, py, rd, ($urandom_range(0, 3) == 0) ? 8'($urandom) : rand_occ());
  endtask

  task automatic rand_phase(int n, int max_r);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) push_write(16'($urandom), rand_occ());
      else rand_query(max_r);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    for (int i = 0; i < LOAD_CELLS; i++) push_write(16'(i), rand_occ());
    set_geometry(0, 0, 65536, 256, 2);
    // directed: field extremes, edges of the grid, radius cases
    push_write(16'd0, 8'sh80);
    push_write(16'hFFFF, 8'sd127);
    push_write(16'd257, 8'sd127);
    push_query(0, 0, 0, 8'sh80);
    push_query(0, 0, 65536, 8'sd127);
    push_query(32'h00FF_FFFF, 32'h0001_FFFF, 3 * 65536, 8'sd127);
    push_query(32'h0100_0000, 0, 65536, 8'sd0);
    push_query(0, 32'h0002_0000, 65536, 8'sd0);
    push_query(-1, 100, 65536, 8'sd0);
    push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 65536, 8'sd0);
    push_query(-32'sh8000_0000, 0, 65536, 8'sd0);
    push_query(65536 * 5 + 77, 65536 + 3, -32'sh8000_0000, 8'sh80);
    push_query(65536 * 5 + 77, 65536 + 3, -1, 8'sd50);
    push_query(65536 * 128, 65536, 32'h7FFF_FFFF, 8'sd127);
    push_query(65536 * 40, 0, 2 * 65536, 8'sd127);
    rand_phase(120, 3);
    set_geometry(0, 0, 65536, 2, 256);
    push_query(65536, 65536 * 200, 32'h7FFF_FFFF, 8'sh80);
    rand_phase(120, 3);
    // tiny grid, unit cells
    set_geometry(32'h8000_0000, 32'h7FFF_FF00, 1, 1, 1);
    push_query(32'h8000_0000, 32'h7FFF_FF00, 0, 8'sh80);
    rand_phase(100, 3);
    // huge cells, far obstacles saturate
    set_geometry(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 2, 2);
    push_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 8'sh80);
    push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'sh80);
    rand_phase(100, 2);
    set_geometry($urandom, $urandom, $urandom_range(1, 5000), 256, 2);
    rand_phase(120, 3);
    set_geometry(32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000, 2, 256);
    rand_phase(100, 3);
    set_geometry(32'h7FFF_FFFF, 0, 65536, 16, 16);
    rand_phase(100, 20);
    // bad geometry
    set_geometry(0, 0, 0, 8, 8);
    rand_phase(30, 2);
    set_geometry(0, 0, 65536, 0, 8);
    rand_phase(30, 2);
    set_geometry(0, 0, 65536, 8, 0);
    rand_phase(30, 2);
    set_geometry(0, 0, 65536, 257, 8);
    rand_phase(30, 2);
    set_geometry(0, 0, 65536, 8, 511);
    rand_phase(30, 2);
    set_geometry($urandom, $urandom, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF);
    rand_phase(20, 2);
    set_geometry(-32'sd1000, -32'sd1000, 12345, 37, 13);
    rand_phase(180, 4);
    set_geometry(0, 0, 65536, 32, 16);
    rand_phase(150, 3);
    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0 && clear_q.size() == 0) begin
      $display("grid_window_nearest_obstacle_core: match");
    end else begin
      $display("grid_window_nearest_obstacle_core: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: grid_window_nearest_obstacle_core.f
rtl/gwno_pkg.sv
rtl/gwno_ram.sv
rtl/gwno_ctrl.sv
rtl/gwno_dp.sv
rtl/grid_window_nearest_obstacle_core.sv
test/tb_grid_window_nearest_obstacle_core.sv
